/* hw/rtl/bilevel_quadtree_encoder_assert.svh */
// Assertion macros for the bilevel quadtree encoder checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef BILEVEL_QUADTREE_ENCODER_ASSERT_SVH
`define BILEVEL_QUADTREE_ENCODER_ASSERT_SVH

// An antecedent that must be followed by a consequent in the same cycle.
`define QTE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quadtree encoder check failed");

// An antecedent that must be followed by a consequent in the next cycle.
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quadtree encoder check failed");

`endif

/* hw/rtl/qte_pkg.sv */
// Shared types and constants of the bilevel quadtree encoder.
// No dependencies.
package qte_pkg;

	localparam int SideW = 3;
	localparam logic [SideW-1:0] SIDE_LOG2_RST = 3'd6;

	localparam logic [1:0] SYM_WHITE = 2'd0;
	localparam logic [1:0] SYM_BLACK = 2'd1;
	localparam logic [1:0] SYM_SPLIT = 2'd2;

	localparam logic PHASE_LOADING  = 1'b0;
	localparam logic PHASE_EMITTING = 1'b1;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_POP  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

/* hw/rtl/bilevel_quadtree_encoder.sv */
// Bilevel quadtree encoder: loads a square image of side 2^side_log2 one pixel per item in
// raster order, then answers each fetch item with the next symbol of the image's pre-order
// quadtree code (white, black or split), marking the final symbol with last. A fetch reads
// its region from the pixel memory one pixel per cycle, up to 4^(side_log2 - depth) pixels,
// until it meets a pixel that differs from the first one or reaches the end of the region;
// after a leaf it climbs back over each level whose four quadrants are done. Out-of-place
// items get a result with error set. The pixel memory is not cleared after reset; a new
// image overwrites it. side_log2 is taken only between images.
module bilevel_quadtree_encoder #(
	parameter int MAX_SIDE_LOG2 = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [qte_pkg::SideW-1:0] side_log2,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic                     pixel,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               symbol,
	output logic                     last,
	output logic                     error
);

	import qte_pkg::*;

	// Widths that follow from the largest image side.
	localparam int M      = MAX_SIDE_LOG2;
	localparam int AW     = (M > 0) ? 2 * M : 1;
	localparam int CW     = 2 * M + 1;
	localparam int RW     = (M > 0) ? M : 1;
	localparam int DW     = (M > 0) ? $clog2(M + 1) : 1;
	localparam int PATH_N = (M > 0) ? M : 1;
	localparam int IW     = (PATH_N > 1) ? $clog2(PATH_N) : 1;

	state_t            state_q;
	logic              phase_q;
	logic [SideW-1:0]  side_q;
	logic [CW-1:0]     lc_q;
	logic [1:0]        path_q [PATH_N];
	logic [DW-1:0]     depth_q;

	// Scan of the current region.
	logic [RW-1:0]     r0_q, c0_q, r_q, c_q, cmax_q;
	logic              iss_done_q, first_iss_q, first_q;
	logic              rd_v_s1, rd_first_s1, rd_end_s1;
	logic [1:0]        sym_q;
	logic              last_q;

	// Output register.
	logic              out_v_q;
	logic [1:0]        out_sym_q;
	logic              out_last_q, out_err_q;

	logic              slot_free, accept, out_set;
	logic [DW-1:0]     lg, dm1;
	logic [RW-1:0]     r0_d, c0_d, cmax_d;
	logic [CW-1:0]     lc_inc, total;
	logic [AW-1:0]     waddr, raddr;
	logic              mem_we, mem_re, rdata, scan_end;
	logic [RW-1:0]     scan_row, scan_col;

	// The side in use never exceeds what the store can hold.
	assign lg = (int'(side_q) > M) ? DW'(M) : DW'(side_q);

	assign slot_free = !out_v_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && slot_free);
	assign accept    = in_valid && !in_stall;

	// A result is offered for an item out of place, or once a fetch has its symbol.
	assign out_set = (accept && (((action == ACT_LOAD) && (phase_q == PHASE_EMITTING)) ||
		((action == ACT_FETCH) && (phase_q == PHASE_LOADING)))) ||
		((state_q == ST_EMIT) && slot_free);

	// Load address: row and column of the next raster pixel.
	assign lc_inc = lc_q + CW'(1);
	assign total  = CW'(1) << (2 * int'(lg));
	assign waddr  = (AW'(lc_q >> lg) << M) | AW'(lc_q & ((CW'(1) << lg) - CW'(1)));
	assign mem_we = accept && (action == ACT_LOAD) && (phase_q == PHASE_LOADING);

	// Origin and size of the region that the quadrant path points at.
	always_comb begin
		int sh;
		r0_d = '0;
		c0_d = '0;
		for (int d = 0; d < PATH_N; d++) begin
			sh = int'(lg) - 1 - d;
			if (d < int'(depth_q)) begin
				r0_d = r0_d | (RW'(path_q[d][1]) << sh);
				c0_d = c0_d | (RW'(path_q[d][0]) << sh);
			end
		end
		cmax_d = RW'((1 << int'(lg - depth_q)) - 1);
	end

	assign scan_row = r0_q + r_q;
	assign scan_col = c0_q + c_q;
	assign raddr    = (AW'(scan_row) << M) | AW'(scan_col);
	assign scan_end = (r_q == cmax_q) && (c_q == cmax_q);
	assign mem_re   = (state_q == ST_SCAN) && !iss_done_q;
	assign dm1      = depth_q - DW'(1);

	// Loads and reads never overlap: the memory is written only while idle.
	qte_pix_mem #(.AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (pixel),
		.re    (mem_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PHASE_LOADING;
			side_q      <= SIDE_LOG2_RST;
			lc_q        <= '0;
			depth_q     <= '0;
			for (int i = 0; i < PATH_N; i++) begin
				path_q[i] <= '0;
			end
			out_v_q     <= 1'b0;
			rd_v_s1     <= 1'b0;
			iss_done_q  <= 1'b0;
		end else begin
			if (out_set) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (cfg_we && (phase_q == PHASE_LOADING) && (lc_q == '0)) begin
				side_q <= side_log2;
			end
			rd_v_s1 <= mem_re;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_LOAD) begin
							if (phase_q == PHASE_LOADING) begin
								if (lc_inc >= total) begin
									lc_q    <= '0;
									depth_q <= '0;
									for (int i = 0; i < PATH_N; i++) begin
										path_q[i] <= '0;
									end
									phase_q <= PHASE_EMITTING;
								end else begin
									lc_q <= lc_inc;
								end
							end
						end else if (phase_q == PHASE_EMITTING) begin
							iss_done_q <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (mem_re && scan_end) begin
						iss_done_q <= 1'b1;
					end
					if (rd_v_s1) begin
						if (rd_first_s1) begin
							if (rd_end_s1) begin
								state_q <= ST_POP;
							end
						end else if ((rdata != first_q) || rd_end_s1) begin
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					if (sym_q == SYM_SPLIT) begin
						path_q[depth_q[IW-1:0]] <= '0;
						depth_q <= depth_q + DW'(1);
						state_q <= ST_EMIT;
					end else if (depth_q == '0) begin
						phase_q <= PHASE_LOADING;
						lc_q    <= '0;
						for (int i = 0; i < PATH_N; i++) begin
							path_q[i] <= '0;
						end
						state_q <= ST_EMIT;
					end else if (path_q[dm1[IW-1:0]] == 2'd3) begin
						depth_q <= dm1;
					end else begin
						path_q[dm1[IW-1:0]] <= path_q[dm1[IW-1:0]] + 2'd1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan datapath and result payload.
	always_ff @(posedge clk) begin
		rd_first_s1 <= first_iss_q;
		rd_end_s1   <= scan_end;
		if (mem_re) begin
			first_iss_q <= 1'b0;
			if (c_q == cmax_q) begin
				c_q <= '0;
				r_q <= r_q + RW'(1);
			end else begin
				c_q <= c_q + RW'(1);
			end
		end
		if (state_q == ST_IDLE) begin
			r0_q        <= r0_d;
			c0_q        <= c0_d;
			cmax_q      <= cmax_d;
			r_q         <= '0;
			c_q         <= '0;
			first_iss_q <= 1'b1;
			last_q      <= 1'b0;
			if (accept) begin
				out_sym_q  <= SYM_WHITE;
				out_last_q <= 1'b0;
				out_err_q  <= 1'b1;
			end
		end
		if ((state_q == ST_SCAN) && rd_v_s1) begin
			if (rd_first_s1) begin
				first_q <= rdata;
				sym_q   <= rdata ? SYM_BLACK : SYM_WHITE;
			end else if (rdata != first_q) begin
				sym_q <= SYM_SPLIT;
			end
		end
		if ((state_q == ST_POP) && (sym_q != SYM_SPLIT) && (depth_q == '0)) begin
			last_q <= 1'b1;
		end
		if ((state_q == ST_EMIT) && slot_free) begin
			out_sym_q  <= sym_q;
			out_last_q <= last_q;
			out_err_q  <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign symbol    = out_sym_q;
	assign last      = out_last_q;
	assign error     = out_err_q;

endmodule

/* hw/rtl/qte_pix_mem.sv */
// Pixel store of the quadtree encoder: one bit per entry, synchronous read.
// Depends on nothing.
module qte_pix_mem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/qte_checker.sv */
// Port-level checks of the bilevel quadtree encoder, bound to its top level.
// Depends on bilevel_quadtree_encoder_assert.svh.
`include "bilevel_quadtree_encoder_assert.svh"

module qte_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] symbol,
	input logic       last,
	input logic       error
);

	// A stalled result stays offered.
	`QTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// An error item carries no code symbol and no end mark.
	`QTE_ASSERT_IMPL(a_err_clean, out_valid && error, (symbol == 2'd0) && !last)
	// Symbol code three is never produced.
	`QTE_ASSERT_IMPL(a_sym_range, out_valid, symbol != 2'd3)
	// The final symbol of a code is always a colour, never a split.
	`QTE_ASSERT_IMPL(a_last_leaf, out_valid && last, symbol != 2'd2)

endmodule

bind bilevel_quadtree_encoder qte_checker u_qte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.symbol    (symbol),
	.last      (last),
	.error     (error)
);

/* tb/tb_bilevel_quadtree_encoder.sv */
// Self-checking testbench for the bilevel quadtree encoder: random images, fetch streams and
// misplaced items, checked against a cycle-free predictor of the quadtree code.
// Depends on qte_pkg and the bilevel_quadtree_encoder top level.
module tb_bilevel_quadtree_encoder;
	import qte_pkg::*;

	localparam int MAXLG      = 6;
	localparam int WATCH_LIMIT = 40000;
	localparam int SETTLE      = 12;

	typedef struct packed {
		logic act;
		logic pix;
	} req_t;

	typedef struct packed {
		logic [1:0] sym;
		logic       lst;
		logic       err;
	} code_sym_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [SideW-1:0] side_log2;
	logic             in_valid;
	logic             in_stall;
	logic             action;
	logic             pixel;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       symbol;
	logic             last;
	logic             error;

	bilevel_quadtree_encoder dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .side_log2(side_log2),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.symbol(symbol), .last(last), .error(error)
	);

	// Items waiting to be offered, and symbols still owed by the block.
	req_t      pending_reqs[$];
	code_sym_t owed_syms[$];

	// Predictor state: its own image store, load position and quadrant path.
	logic            img_store[4096];
	int unsigned     loaded_px;
	logic [1:0]      quad_path[MAXLG+1];
	int unsigned     path_lvl;
	logic            phase;
	logic [SideW-1:0] side_reg;

	// Stimulus image, in raster order at the side in use.
	logic            gen_img[4096];
	logic            blk_val[4096];

	int fails, n_items, n_results, n_images, n_errs;
	int idle_cyc;
	bit in_took, out_took;
	bit quiet;
	bit hold_req;
	int hold_left, out_wait, in_gap;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(input string what, input logic [3:0] got, input logic [3:0] want);
		fails++;
		$display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
			n_results);
	endtask

	function automatic int unsigned eff_side();
		return (side_reg > MAXLG) ? MAXLG : side_reg;
	endfunction

	// Colour of the current region, or split when it is mixed.
	function automatic logic [1:0] region_colour(int unsigned lg);
		int unsigned r0, c0, sz, dep;
		logic first;
		r0 = 0;
		c0 = 0;
		dep = (path_lvl > lg) ? lg : path_lvl;
		for (int d = 0; d < dep; d++) begin
			r0 |= quad_path[d][1] << (lg - 1 - d);
			c0 |= quad_path[d][0] << (lg - 1 - d);
		end
		sz = 1 << (lg - dep);
		first = img_store[(r0 << MAXLG) | c0];
		for (int r = 0; r < sz; r++)
			for (int c = 0; c < sz; c++)
				if (img_store[((r0 + r) << MAXLG) | (c0 + c)] != first)
					return SYM_SPLIT;
		return first ? SYM_BLACK : SYM_WHITE;
	endfunction

	// Advances the predictor by one accepted item and queues what it owes.
	task automatic predict_item(input req_t rq);
		int unsigned lg;
		code_sym_t cs;
		lg = eff_side();
		cs = '0;
		if (rq.act == ACT_LOAD) begin
			if (phase != PHASE_LOADING) begin
				cs.err = 1'b1;
				owed_syms.push_back(cs);
				return;
			end
			img_store[((loaded_px >> lg) << MAXLG) | (loaded_px & ((1 << lg) - 1))] = rq.pix;
			loaded_px++;
			if (loaded_px >= (1 << (2 * lg))) begin
				loaded_px = 0;
				path_lvl = 0;
				foreach (quad_path[i]) quad_path[i] = 2'd0;
				phase = PHASE_EMITTING;
			end
			return;
		end
		if (phase != PHASE_EMITTING) begin
			cs.err = 1'b1;
			owed_syms.push_back(cs);
			return;
		end
		cs.sym = region_colour(lg);
		if (cs.sym == SYM_SPLIT && path_lvl < lg) begin
			quad_path[path_lvl] = 2'd0;
			path_lvl++;
		end else begin
			if (cs.sym == SYM_SPLIT)
				cs.sym = img_store[0] ? SYM_BLACK : SYM_WHITE;
			while (path_lvl > 0 && quad_path[path_lvl-1] == 2'd3)
				path_lvl--;
			if (path_lvl == 0) begin
				cs.lst = 1'b1;
				phase = PHASE_LOADING;
				loaded_px = 0;
				foreach (quad_path[i]) quad_path[i] = 2'd0;
			end else begin
				quad_path[path_lvl-1] = quad_path[path_lvl-1] + 2'd1;
			end
		end
		owed_syms.push_back(cs);
	endtask

	// Symbols in the code of a square of the stimulus image.
	function automatic int code_len(int r0, int c0, int sz, int lg);
		logic first;
		bit mixed;
		first = gen_img[(r0 << lg) | c0];
		mixed = 0;
		for (int r = 0; r < sz; r++)
			for (int c = 0; c < sz; c++)
				if (gen_img[((r0 + r) << lg) | (c0 + c)] != first)
					mixed = 1;
		if (!mixed || sz == 1)
			return 1;
		return 1 + code_len(r0, c0, sz/2, lg) + code_len(r0, c0 + sz/2, sz/2, lg)
			+ code_len(r0 + sz/2, c0, sz/2, lg) + code_len(r0 + sz/2, c0 + sz/2, sz/2, lg);
	endfunction

	// Queues one whole image and its fetches, with misplaced items mixed in when
	// noise is asked for. The image is made of blocks of side 2^blk with a few flips.
	task automatic queue_image(input int lg, input int blk, input int flip_pct,
			input bit noise);
		int side_px, len;
		req_t rq;
		side_px = 1 << lg;
		for (int i = 0; i < 4096; i++) blk_val[i] = $urandom_range(0, 1);
		for (int r = 0; r < side_px; r++)
			for (int c = 0; c < side_px; c++)
				gen_img[(r << lg) | c] = blk_val[((r >> blk) << MAXLG) | (c >> blk)]
					^ ($urandom_range(0, 99) < flip_pct);
		for (int i = 0; i < side_px * side_px; i++) begin
			if (noise && $urandom_range(0, 19) == 0) begin
				rq.act = ACT_FETCH;
				rq.pix = $urandom_range(0, 1);
				pending_reqs.push_back(rq);
			end
			rq.act = ACT_LOAD;
			rq.pix = gen_img[i];
			pending_reqs.push_back(rq);
		end
		len = code_len(0, 0, side_px, lg);
		for (int i = 0; i < len; i++) begin
			if (noise && $urandom_range(0, 11) == 0) begin
				rq.act = ACT_LOAD;
				rq.pix = $urandom_range(0, 1);
				pending_reqs.push_back(rq);
			end
			rq.act = ACT_FETCH;
			rq.pix = $urandom_range(0, 1);
			pending_reqs.push_back(rq);
		end
		if (noise && $urandom_range(0, 3) == 0) begin
			rq.act = ACT_FETCH;
			rq.pix = 1'b0;
			pending_reqs.push_back(rq);
		end
		n_images++;
	endtask

	// Waits until the sender has nothing left and every symbol has come back, then lets
	// the block settle so a trailing load has certainly been taken in.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || owed_syms.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// The register may only change while the block waits for the first pixel of an image.
	task automatic write_side(input logic [SideW-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		side_log2 <= v;
		@(posedge clk);
		if (phase == PHASE_LOADING && loaded_px == 0)
			side_reg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender: offers the next queued item once the previous one has gone, after a gap.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (pending_reqs.size() != 0) begin
				req_t rq;
				rq = pending_reqs.pop_front();
				action <= rq.act;
				pixel <= rq.pix;
				in_valid <= 1'b1;
				in_gap = quiet ? 0 : $urandom_range(0, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a random stall after each symbol, and one long hold-off when it is asked for.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (out_wait > 0) begin
			out_stall <= 1'b1;
			out_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Checker: compares each symbol with the oldest one owed, then predicts for the item
	// taken at this edge. A symbol never belongs to an item taken at the same edge.
	always @(posedge clk) begin
		in_took = arst_n && in_valid && !in_stall;
		out_took = arst_n && out_valid && !out_stall;
		if (out_took) begin
			n_results++;
			out_wait = quiet ? 0 : $urandom_range(0, 6);
			if (owed_syms.size() == 0) begin
				fails++;
				$display("symbol %0d arrived with nothing owed", symbol);
			end else begin
				code_sym_t cs;
				cs = owed_syms.pop_front();
				if (symbol !== cs.sym) report("symbol", 4'(symbol), 4'(cs.sym));
				if (last !== cs.lst) report("last", 4'(last), 4'(cs.lst));
				if (error !== cs.err) report("error", 4'(error), 4'(cs.err));
				if (cs.err) n_errs++;
			end
		end
		if (in_took) begin
			req_t rq;
			rq.act = action;
			rq.pix = pixel;
			n_items++;
			predict_item(rq);
		end
		if (in_took || out_took || !arst_n)
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= WATCH_LIMIT) begin
			$display("no progress for %0d cycles, %0d symbols owed", idle_cyc,
				owed_syms.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		req_t rq;
		int lg;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		side_log2 = SIDE_LOG2_RST;
		in_valid = 1'b0;
		action = ACT_LOAD;
		pixel = 1'b0;
		out_stall = 1'b0;
		fails = 0; n_items = 0; n_results = 0; n_images = 0; n_errs = 0;
		idle_cyc = 0; in_gap = 0; hold_left = 0; out_wait = 0;
		quiet = 1; hold_req = 0;
		foreach (img_store[i]) img_store[i] = 1'b0;
		foreach (quad_path[i]) quad_path[i] = 2'd0;
		loaded_px = 0; path_lvl = 0; phase = PHASE_LOADING; side_reg = SIDE_LOG2_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a one-pixel image of each colour, fetches and loads out of place.
		write_side(3'd0);
		rq.act = ACT_FETCH; rq.pix = 1'b1; pending_reqs.push_back(rq);
		rq.act = ACT_LOAD;  rq.pix = 1'b1; pending_reqs.push_back(rq);
		rq.act = ACT_LOAD;  rq.pix = 1'b0; pending_reqs.push_back(rq);
		rq.act = ACT_FETCH; rq.pix = 1'b0; pending_reqs.push_back(rq);
		rq.act = ACT_LOAD;  rq.pix = 1'b0; pending_reqs.push_back(rq);
		rq.act = ACT_FETCH; rq.pix = 1'b1; pending_reqs.push_back(rq);
		rq.act = ACT_FETCH; rq.pix = 1'b0; pending_reqs.push_back(rq);
		wait_drained();
		// Two by two: a checkerboard splits down to single pixels, then all white.
		write_side(3'd1);
		foreach (gen_img[i]) gen_img[i] = 1'b0;
		for (int i = 0; i < 4; i++) begin
			rq.act = ACT_LOAD; rq.pix = i[0] ^ i[1]; pending_reqs.push_back(rq);
		end
		for (int i = 0; i < 5; i++) begin
			rq.act = ACT_FETCH; rq.pix = 1'b0; pending_reqs.push_back(rq);
		end
		for (int i = 0; i < 4; i++) begin
			rq.act = ACT_LOAD; rq.pix = 1'b0; pending_reqs.push_back(rq);
		end
		rq.act = ACT_FETCH; rq.pix = 1'b0; pending_reqs.push_back(rq);
		wait_drained();

		// A side above the largest one is taken between images; a stray fetch is flagged
		// and the side is then moved on before any pixel arrives.
		write_side(3'd7);
		rq.act = ACT_FETCH; rq.pix = 1'b0; pending_reqs.push_back(rq);
		wait_drained();

		// Long hold-off on the receiver while a busy image streams in.
		write_side(3'd3);
		queue_image(3, 0, 0, 1);
		hold_req = 1;
		wait_drained();

		// Random phases, mostly small sides, a few at sixteen by sixteen.
		quiet = 0;
		while (n_items < 900) begin
			lg = $urandom_range(0, 9);
			lg = (lg < 2) ? lg + 1 : (lg < 8) ? 2 + (lg & 1) : (lg == 8) ? 0 : 4;
			write_side(lg[SideW-1:0]);
			quiet = ($urandom_range(0, 4) == 0);
			for (int k = $urandom_range(1, 3); k > 0; k--)
				queue_image(lg, $urandom_range(0, lg), $urandom_range(0, 3) * 4, 1);
			wait_drained();
		end
		wait_drained();

		$display("%0d items over %0d images, %0d symbols checked of which %0d flagged out of place",
			n_items, n_images, n_results, n_errs);
		$display("sides 0 to 4 and an oversized side write, with random and held back-pressure");
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
